@@ hw/rtl/swd_pkg.sv @@
// Shared constants and types for the stack with delete-by-value.
// No dependencies; the RTL files but swd_ram refer to it by scoped names, the testbench files import it.
package swd_pkg;

	localparam int DEPTH  = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int OCC_W  = 6;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SH_RD,
		S_SH_WR
	} state_t;

endpackage

@@ hw/rtl/swd_in_if.sv @@
// Request channel: operation and value, valid/ready handshake.
// Depends on swd_pkg for the data width.
interface swd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           operation;
	logic signed [swd_pkg::DATA_W-1:0]    item_value;

	modport source (output valid, output operation, output item_value, input ready);
	modport sink   (input valid, input operation, input item_value, output ready);
endinterface

@@ hw/rtl/swd_out_if.sv @@
// Response channel: status, occupancy and top of stack, valid/ready handshake.
// Depends on swd_pkg for widths.
interface swd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           status;
	logic [swd_pkg::OCC_W-1:0]            occupancy;
	logic signed [swd_pkg::DATA_W-1:0]    top_value;
	logic                                 top_valid;

	modport source (output valid, output status, output occupancy, output top_value,
		output top_valid, input ready);
	modport sink   (input valid, input status, input occupancy, input top_value,
		input top_valid, output ready);
endinterface

@@ hw/rtl/stack_with_delete_by_value.sv @@
// LIFO stack of signed 32-bit words with delete-by-value, held in one RAM.
// Depends on swd_pkg, swd_in_if, swd_out_if and swd_ram.
//
// One request gives one response. A request is taken whenever the block is idle and
// the response register is empty or being emptied. Push, pop of the last entry,
// delete of the top when it is the only entry, every refused operation and the
// unused operation code finish in the idle state. Pop, and delete that hits the
// top entry, pass S_POP, where the new top is read back from the RAM. Any other
// delete walks down from the entry below the top (S_SRCH_RD, S_SRCH_CMP), then
// closes the gap (S_SH_RD, S_SH_WR), paced by the single read port and registered
// read data of the RAM. The top value lives in a register, so the entry on top is
// never read to find it.
module stack_with_delete_by_value (
	input  logic      clk,
	input  logic      arst_n,
	swd_in_if.sink    req,
	swd_out_if.source rsp
);

	localparam int AW = swd_pkg::ADDR_W;
	localparam int CW = swd_pkg::CNT_W;
	localparam int DW = swd_pkg::DATA_W;

	swd_pkg::state_t  state_q, state_d;
	logic [CW-1:0]    count_q;
	logic [DW-1:0]    top_q;
	logic [DW-1:0]    val_q;
	logic [AW-1:0]    idx_q, idx_d;

	logic             out_valid_q;
	swd_pkg::status_t out_status_q;
	logic [swd_pkg::OCC_W-1:0] out_occ_q;
	logic [DW-1:0]    out_top_q;
	logic             out_topv_q;

	logic             out_free;
	logic [CW-1:0]    cnt_m1, cnt_m2;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [DW-1:0]    ram_wdata, ram_rdata;

	logic             fin;
	swd_pkg::status_t fin_status;
	logic [CW-1:0]    fin_count;
	logic [DW-1:0]    fin_top;

	assign out_free = !out_valid_q || rsp.ready;
	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);

	swd_ram #(
		.WIDTH(DW),
		.DEPTH(swd_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		ram_we     = 1'b0;
		ram_waddr  = idx_q;
		ram_wdata  = ram_rdata;
		ram_re     = 1'b0;
		ram_raddr  = idx_q;
		fin        = 1'b0;
		fin_status = swd_pkg::ST_DONE;
		fin_count  = count_q;
		fin_top    = top_q;
		req.ready  = 1'b0;

		case (state_q)
			swd_pkg::S_IDLE: begin
				req.ready = out_free;
				if (req.valid && out_free) begin
					case (swd_pkg::op_t'(req.operation))
						swd_pkg::OP_PUSH: begin
							fin = 1'b1;
							if (count_q == CW'(swd_pkg::DEPTH)) begin
								fin_status = swd_pkg::ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = count_q[AW-1:0];
								ram_wdata = req.item_value;
								fin_count = count_q + CW'(1);
								fin_top   = req.item_value;
							end
						end
						swd_pkg::OP_POP: begin
							if (count_q == '0) begin
								fin        = 1'b1;
								fin_status = swd_pkg::ST_EMPTY;
							end else if (count_q == CW'(1)) begin
								fin       = 1'b1;
								fin_count = '0;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = cnt_m2[AW-1:0];
								state_d   = swd_pkg::S_POP;
							end
						end
						swd_pkg::OP_DELETE: begin
							if (count_q == '0) begin
								fin        = 1'b1;
								fin_status = swd_pkg::ST_NOTFOUND;
							end else if (req.item_value == top_q) begin
								// hit on top: behaves as a pop
								if (count_q == CW'(1)) begin
									fin       = 1'b1;
									fin_count = '0;
								end else begin
									ram_re    = 1'b1;
									ram_raddr = cnt_m2[AW-1:0];
									state_d   = swd_pkg::S_POP;
								end
							end else if (count_q == CW'(1)) begin
								fin        = 1'b1;
								fin_status = swd_pkg::ST_NOTFOUND;
							end else begin
								idx_d   = cnt_m2[AW-1:0];
								state_d = swd_pkg::S_SRCH_RD;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			swd_pkg::S_POP: begin
				fin       = 1'b1;
				fin_count = cnt_m1;
				fin_top   = ram_rdata;
				state_d   = swd_pkg::S_IDLE;
			end
			swd_pkg::S_SRCH_RD: begin
				ram_re  = 1'b1;
				state_d = swd_pkg::S_SRCH_CMP;
			end
			swd_pkg::S_SRCH_CMP: begin
				if (ram_rdata == val_q) begin
					state_d = swd_pkg::S_SH_RD;
				end else if (idx_q == '0) begin
					fin        = 1'b1;
					fin_status = swd_pkg::ST_NOTFOUND;
					state_d    = swd_pkg::S_IDLE;
				end else begin
					idx_d   = idx_q - AW'(1);
					state_d = swd_pkg::S_SRCH_RD;
				end
			end
			swd_pkg::S_SH_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q + AW'(1);
				state_d   = swd_pkg::S_SH_WR;
			end
			swd_pkg::S_SH_WR: begin
				// move entry idx+1 down into idx; top stays as it was
				ram_we = 1'b1;
				if (idx_q == cnt_m2[AW-1:0]) begin
					fin       = 1'b1;
					fin_count = cnt_m1;
					state_d   = swd_pkg::S_IDLE;
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = swd_pkg::S_SH_RD;
				end
			end
			default: begin
				state_d = swd_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swd_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) begin
				count_q     <= fin_count;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (req.valid && req.ready) begin
			val_q <= req.item_value;
		end
		if (fin) begin
			top_q        <= fin_top;
			out_status_q <= fin_status;
			out_occ_q    <= swd_pkg::OCC_W'(fin_count);
			out_top_q    <= (fin_count != '0) ? fin_top : '0;
			out_topv_q   <= (fin_count != '0);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.occupancy = out_occ_q;
	assign rsp.top_value = out_top_q;
	assign rsp.top_valid = out_topv_q;

endmodule

@@ hw/rtl/swd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module swd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ tb/swd_tb_pkg.sv @@
// Scoreboard for the stack with delete-by-value: tracks the stack contents and
// checks every response against the outcome of the accepted requests. Depends on swd_pkg.
`timescale 1ns / 1ps
package swd_tb_pkg;

	import swd_pkg::*;

	// operation code outside op_t: the block leaves the stack alone
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]               op;
		logic signed [DATA_W-1:0] arg;
		status_t                  status;
		logic [OCC_W-1:0]         occupancy;
		logic signed [DATA_W-1:0] top_value;
		logic                     top_valid;
	} stack_rsp_t;

	class stack_tracker;
		logic signed [DATA_W-1:0] held [DEPTH];
		int                       depth_now;
		stack_rsp_t               awaited_rsp [$];
		int                       failures;
		int                       checked;
		int                       op_seen [4];
		int                       status_seen [4];
		int                       peak;

		function new();
			depth_now = 0;
			failures  = 0;
			checked   = 0;
			peak      = 0;
			foreach (op_seen[k]) op_seen[k] = 0;
			foreach (status_seen[k]) status_seen[k] = 0;
		endfunction

		function int pending();
			return awaited_rsp.size();
		endfunction

		function logic signed [DATA_W-1:0] held_value();
			return held[$urandom_range(depth_now - 1, 0)];
		endfunction

		function void take_request(logic [1:0] op, logic signed [DATA_W-1:0] v);
			stack_rsp_t r;
			bit         hit;
			r.op     = op;
			r.arg    = v;
			r.status = ST_DONE;
			case (op)
				OP_PUSH: begin
					if (depth_now >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						held[depth_now] = v;
						depth_now++;
					end
				end
				OP_POP: begin
					if (depth_now == 0) r.status = ST_EMPTY;
					else depth_now--;
				end
				OP_DELETE: begin
					// first match from the top, the rest slides down one slot
					r.status = ST_NOTFOUND;
					hit = 1'b0;
					for (int i = depth_now - 1; i >= 0 && !hit; i--) begin
						if (held[i] == v) begin
							for (int j = i; j < depth_now - 1; j++) held[j] = held[j + 1];
							depth_now--;
							hit = 1'b1;
							r.status = ST_DONE;
						end
					end
				end
				default: ;
			endcase
			r.occupancy = OCC_W'(depth_now);
			r.top_valid = (depth_now > 0);
			r.top_value = (depth_now > 0) ? held[depth_now - 1] : '0;
			op_seen[op]++;
			status_seen[r.status]++;
			if (depth_now > peak) peak = depth_now;
			awaited_rsp.push_back(r);
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= 10) $display("%s", msg);
		endfunction

		function void check_response(logic [1:0] st, logic [OCC_W-1:0] occ,
				logic signed [DATA_W-1:0] tv, logic tvld);
			stack_rsp_t e;
			checked++;
			if (awaited_rsp.size() == 0) begin
				note_failure($sformatf("unexpected response: status %0d occ %0d top %0d/%0b",
					st, occ, tv, tvld));
				return;
			end
			e = awaited_rsp.pop_front();
			if (st !== e.status || occ !== e.occupancy || tv !== e.top_value
					|| tvld !== e.top_valid)
				note_failure($sformatf(
					"mismatch op %0d arg %0d: exp %s occ %0d top %0d/%0b, got %0d occ %0d top %0d/%0b",
					e.op, e.arg, e.status.name(), e.occupancy, e.top_value, e.top_valid,
					st, occ, tv, tvld));
		endfunction
	endclass

endpackage

@@ tb/tb.sv @@
// Top of the testbench for stack_with_delete_by_value: directed and random requests,
// random stalls on both channels. Depends on swd_pkg, the channel interfaces and swd_tb_pkg.
`timescale 1ns / 1ps
module tb;

	import swd_pkg::*;
	import swd_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int CYCLE_LIMIT  = 1000000;

	logic clk;
	logic arst_n;
	bit   steady;

	swd_in_if  req_ch ();
	swd_out_if rsp_ch ();

	stack_tracker sb = new();

	stack_with_delete_by_value DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d responses still awaited", CYCLE_LIMIT,
			sb.pending());
		$display("tb failed");
		$finish;
	end

	// response side: random back-pressure, check every transaction
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				sb.check_response(rsp_ch.status, rsp_ch.occupancy, rsp_ch.top_value,
					rsp_ch.top_valid);
			rsp_ch.ready <= steady || ($urandom_range(99) >= 32);
		end
	end

	// called at a rising edge; returns at the edge where the transaction is taken
	task automatic send_req(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
		if (!steady && $urandom_range(99) < 32) begin
			req_ch.valid      <= 1'b0;
			req_ch.operation  <= 2'($urandom);
			req_ch.item_value <= $urandom;
			do @(posedge clk); while ($urandom_range(99) < 32);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.item_value <= v;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.take_request(op, v);
	endtask

	function automatic logic [1:0] pick_op(input int mode);
		int r;
		r = $urandom_range(99);
		case (mode)
			0:       return (r < 65) ? OP_PUSH : (r < 75) ? OP_POP : (r < 96) ? OP_DELETE : OP_UNUSED;
			1:       return (r < 35) ? OP_PUSH : (r < 60) ? OP_POP : (r < 96) ? OP_DELETE : OP_UNUSED;
			default: return (r < 15) ? OP_PUSH : (r < 55) ? OP_POP : (r < 96) ? OP_DELETE : OP_UNUSED;
		endcase
	endfunction

	// small values repeat, so deletes hit and duplicates sit in the stack
	function automatic logic signed [DATA_W-1:0] pick_value(input logic [1:0] op);
		int r;
		r = $urandom_range(99);
		if (op == OP_DELETE && sb.depth_now > 0 && r < 60) return sb.held_value();
		if (r < 80) return DATA_W'($signed($urandom_range(7)) - 4);
		return $urandom;
	endfunction

	initial begin
		logic [1:0]               op;
		logic signed [DATA_W-1:0] v;

		steady             = 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.operation  <= OP_PUSH;
		req_ch.item_value <= '0;
		arst_n            <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n            <= 1'b1;
		@(posedge clk);

		// refused operations and the unused code on the empty stack, then extremes and duplicates
		send_req(OP_POP, 0);
		send_req(OP_DELETE, 5);
		send_req(OP_UNUSED, 9);
		send_req(OP_PUSH, 32'sh7fff_ffff);
		send_req(OP_PUSH, 32'sh8000_0000);
		send_req(OP_PUSH, 0);
		send_req(OP_PUSH, -1);
		send_req(OP_UNUSED, -1);
		send_req(OP_DELETE, -1);
		send_req(OP_PUSH, 7);
		send_req(OP_PUSH, 32'sh8000_0000);
		send_req(OP_DELETE, 32'sh8000_0000);
		send_req(OP_DELETE, 32'sh8000_0000);
		send_req(OP_DELETE, 12345);
		send_req(OP_DELETE, 32'sh7fff_ffff);
		send_req(OP_POP, 0);
		send_req(OP_POP, 0);
		send_req(OP_POP, 0);
		send_req(OP_PUSH, 32'sh5555_5555);
		send_req(OP_PUSH, 32'shaaaa_aaaa);
		send_req(OP_DELETE, 32'sh5555_5555);
		send_req(OP_DELETE, 32'shaaaa_aaaa);

		// fill, mixed and drain phases of 100 transactions each
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= 500 && n < 700);
			op = pick_op((n / 100) % 3);
			v  = pick_value(op);
			send_req(op, v);
		end
		steady = 1'b0;
		req_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("%0d responses checked: %0d push, %0d pop, %0d delete, %0d unused code",
			sb.checked, sb.op_seen[OP_PUSH], sb.op_seen[OP_POP], sb.op_seen[OP_DELETE],
			sb.op_seen[OP_UNUSED]);
		$display("refusals: %0d full, %0d empty, %0d not found; deepest stack %0d; failures %0d",
			sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOTFOUND],
			sb.peak, sb.failures);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/swd_pkg.sv
hw/rtl/swd_in_if.sv
hw/rtl/swd_out_if.sv
hw/rtl/swd_ram.sv
hw/rtl/stack_with_delete_by_value.sv
tb/swd_tb_pkg.sv
tb/tb.sv
